// ===== rtl/jts_pkg.sv =====
// Shared types and constants for the joint target smoother.
// Used by every module of the block; no dependencies.
`default_nettype none

package jts_pkg;

    localparam int DEF_MAX_JOINTS = 8;
    localparam int DEF_NUM_ARMS   = 2;
    localparam int FIFO_DEPTH     = 4;

    // pi/180 in unsigned Q0.32
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

    localparam logic [16:0] RST_ALPHA    = 17'd19661;
    localparam logic [30:0] RST_MAX_STEP = 31'd655;
    localparam logic        RST_LIMIT_EN = 1'b1;
    localparam logic [15:0] RST_TIMEOUT  = 16'd100;
    localparam logic        RST_CONV_DEG = 1'b1;
    localparam logic        RST_FOLLOW   = 1'b0;

    typedef enum logic [2:0] {
        CFG_ALPHA    = 3'd0,
        CFG_MAX_STEP = 3'd1,
        CFG_LIMIT_EN = 3'd2,
        CFG_TIMEOUT  = 3'd3,
        CFG_CONV_DEG = 3'd4,
        CFG_FOLLOW   = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_TARGET = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef struct packed {
        logic [16:0] alpha;
        logic [30:0] max_step;
        logic        limit_en;
        logic [15:0] timeout;
        logic        conv_deg;
        logic        follow;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic        arm;
        logic [31:0] value;
        logic        last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CP_RD,
        ST_CP_WR,
        ST_ARM,
        ST_RD,
        ST_MUL,
        ST_CLAMP,
        ST_SUM
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/joint_target_smoother.sv =====
// Joint target smoother top level: configuration registers, input stage,
// command queue and sequencer. Depends on jts_pkg, jts_front, jts_fifo, jts_back.
//
// Channels: target elements and ticks enter on the s-side stream (tuser[0] is
// the operation, tuser[1] the arm, tdata the Q16.16 angle, tlast ends a vector).
// Results leave on the m-side stream, one transaction per joint of each valid
// arm after a tick; tlast marks the final one of that tick.
// Configuration writes use the cfg channel (index, data); it is always ready
// and is to be written only while the block is idle, which the block itself
// does not enforce. A target element passes input staging and queueing before
// the sequencer takes it; the element that ends a vector adds a commit copy, a
// read and a write for each stored joint. A tick visits the arms in turn and,
// for each joint of each valid arm, reads, multiplies, clamps and sums through
// the stores. The sequencer takes no new command until it is back in idle.
// Reset: all arms invalid, counters and fill counts cleared; the stores hold
// no defined value until written.
// Receiver stall: the sequencer waits in its sum stage, the queue fills and
// s_tready drops; no transaction is lost.
`default_nettype none

module joint_target_smoother #(
    parameter int MAX_JOINTS = jts_pkg::DEF_MAX_JOINTS,
    parameter int NUM_ARMS   = jts_pkg::DEF_NUM_ARMS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,    // angle
    input  wire  [1:0]  i_s_tuser,    // operation, arm
    input  wire         i_s_tlast,    // last_element
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,    // position
    output logic [4:0]  o_m_tuser,    // out_arm, joint[2:0], follow
    output logic        o_m_tlast,    // last
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);
    import jts_pkg::*;

    t_cfg r_cfg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    t_cmd push_cmd, pop_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha    <= RST_ALPHA;
            r_cfg.max_step <= RST_MAX_STEP;
            r_cfg.limit_en <= RST_LIMIT_EN;
            r_cfg.timeout  <= RST_TIMEOUT;
            r_cfg.conv_deg <= RST_CONV_DEG;
            r_cfg.follow   <= RST_FOLLOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_cfg.alpha    <= i_cfg_data[16:0];
                CFG_MAX_STEP: r_cfg.max_step <= i_cfg_data[30:0];
                CFG_LIMIT_EN: r_cfg.limit_en <= i_cfg_data[0];
                CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data[15:0];
                CFG_CONV_DEG: r_cfg.conv_deg <= i_cfg_data[0];
                CFG_FOLLOW:   r_cfg.follow   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    jts_front #(
        .NUM_ARMS (NUM_ARMS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    jts_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    jts_back #(
        .MAX_JOINTS (MAX_JOINTS),
        .NUM_ARMS   (NUM_ARMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/jts_front.sv =====
// Input stage: accepts stream transactions, converts degrees to radians when
// enabled, drops elements for absent arms. Depends on jts_pkg.
`default_nettype none

module jts_front #(
    parameter int NUM_ARMS = jts_pkg::DEF_NUM_ARMS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  jts_pkg::t_cfg      i_cfg,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  wire  [31:0]        i_s_tdata,   // angle
    input  wire  [1:0]         i_s_tuser,   // operation, arm
    input  wire                i_s_tlast,   // last_element
    output logic               o_push_valid,
    input  wire                i_push_ready,
    output jts_pkg::t_cmd      o_push_cmd
);
    import jts_pkg::*;

    logic               r_valid;
    logic signed [59:0] r_prod;
    logic [31:0]        r_angle;
    logic               r_conv;
    t_op                r_op;
    logic               r_arm;
    logic               r_last;

    logic signed [59:0] prod;
    logic               keep;
    logic               accept;

    assign prod   = $signed(i_s_tdata) * $signed({1'b0, DEG_TO_RAD_Q32});
    assign keep   = (r_op == OP_TICK) || ({31'b0, r_arm} < 32'(NUM_ARMS));
    assign o_push_valid = r_valid && keep;
    assign o_s_tready   = !r_valid || !keep || i_push_ready;
    assign accept       = i_s_tvalid && o_s_tready;

    always_comb begin
        o_push_cmd.op    = r_op;
        o_push_cmd.arm   = r_arm;
        o_push_cmd.last  = r_last;
        o_push_cmd.value = r_conv ? {{4{r_prod[59]}}, r_prod[59:32]} : r_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (!keep || i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod  <= prod;
            r_angle <= i_s_tdata;
            r_conv  <= i_cfg.conv_deg;
            r_op    <= t_op'(i_s_tuser[0]);
            r_arm   <= i_s_tuser[1];
            r_last  <= i_s_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jts_fifo.sv =====
// Short command queue between the input stage and the sequencer.
// Depends on jts_pkg for the command type and depth.
`default_nettype none

module jts_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push_valid,
    output logic               o_push_ready,
    input  jts_pkg::t_cmd      i_push_cmd,
    output logic               o_pop_valid,
    input  wire                i_pop_ready,
    output jts_pkg::t_cmd      o_pop_cmd
);
    import jts_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_cmd          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != (PW+1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (pop && !push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jts_back.sv =====
// Sequencer: vector commit, per-tick EMA with optional slew clamp, result output register.
// Holds the position, target and shadow stores. Depends on jts_pkg.
`default_nettype none

module jts_back #(
    parameter int MAX_JOINTS = jts_pkg::DEF_MAX_JOINTS,
    parameter int NUM_ARMS   = jts_pkg::DEF_NUM_ARMS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  jts_pkg::t_cfg      i_cfg,
    input  wire                i_pop_valid,
    output logic               o_pop_ready,
    input  jts_pkg::t_cmd      i_pop_cmd,
    output logic               o_m_tvalid,
    input  wire                i_m_tready,
    output logic [31:0]        o_m_tdata,   // position
    output logic [4:0]         o_m_tuser,   // out_arm, joint[2:0], follow
    output logic               o_m_tlast    // last
);
    import jts_pkg::*;

    localparam int CW    = $clog2(MAX_JOINTS + 1);
    localparam int JIW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int DEPTH = NUM_ARMS * MAX_JOINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic LAST_ARM = 1'(NUM_ARMS - 1);

    function automatic logic [AW-1:0] store_addr(input logic arm, input logic [CW-1:0] j);
        logic [AW:0] base;
        base = arm ? (AW+1)'(MAX_JOINTS) : '0;
        return AW'(base + (AW+1)'(j[JIW-1:0]));
    endfunction

    logic [31:0] mem_inc [DEPTH];
    logic [31:0] mem_tgt [DEPTH];
    logic [31:0] mem_cur [DEPTH];

    t_back_state r_state, n_state;
    logic [CW-1:0] r_fill   [NUM_ARMS];
    logic [CW-1:0] n_fill   [NUM_ARMS];
    logic [CW-1:0] r_jc     [NUM_ARMS];
    logic [CW-1:0] n_jc     [NUM_ARMS];
    logic          r_valid  [NUM_ARMS];
    logic          n_valid  [NUM_ARMS];
    logic          r_mism   [NUM_ARMS];
    logic          n_mism   [NUM_ARMS];
    logic [15:0]   r_ticks  [NUM_ARMS];
    logic [15:0]   n_ticks  [NUM_ARMS];
    logic          r_smooth [NUM_ARMS];
    logic          n_smooth [NUM_ARMS];
    logic          r_arm, n_arm;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_len, n_len;
    logic          r_first, n_first;

    logic [31:0]        r_inc_rd, r_tgt_rd, r_cur_rd;
    logic signed [31:0] r_cur, n_cur;
    logic signed [50:0] r_prod, n_prod;
    logic signed [34:0] r_step, n_step;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_pos, n_out_pos;
    logic [4:0]  r_out_user, n_out_user;
    logic        r_out_last, n_out_last;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          we_inc, we_tgt, we_cur;
    logic [31:0]   wr_inc_data, wr_cur_data;

    logic               out_free;
    logic signed [32:0] diff;
    logic signed [34:0] step_raw, lim, sum_step;
    logic signed [35:0] sum;
    logic [31:0]        sat;
    logic               later_valid;
    logic [5:0]         j6;
    logic [CW-1:0]      fill_now;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pos;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;
    assign rd_addr    = store_addr(r_arm, r_j);

    assign diff     = $signed({r_tgt_rd[31], r_tgt_rd}) - $signed({r_cur_rd[31], r_cur_rd});
    assign step_raw = r_prod[50:16];
    assign lim      = $signed({4'b0, i_cfg.max_step});
    assign sum      = $signed({{4{r_cur[31]}}, r_cur}) + $signed({r_step[34], r_step});
    assign j6       = 6'(r_j);

    always_comb begin
        if (!sum[35] && (sum[34:31] != 4'b0000)) begin
            sat = 32'h7FFF_FFFF;
        end else if (sum[35] && (sum[34:31] != 4'b1111)) begin
            sat = 32'h8000_0000;
        end else begin
            sat = sum[31:0];
        end
    end

    always_comb begin
        sum_step = step_raw;
        if (i_cfg.limit_en) begin
            if (step_raw > lim) begin
                sum_step = lim;
            end else if (step_raw < -lim) begin
                sum_step = -lim;
            end
        end
    end

    always_comb begin
        later_valid = 1'b0;
        for (int a = 0; a < NUM_ARMS; a++) begin
            if ((1'(a) > r_arm) && r_valid[a]) begin
                later_valid = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_jc        = r_jc;
        n_valid     = r_valid;
        n_mism      = r_mism;
        n_ticks     = r_ticks;
        n_smooth    = r_smooth;
        n_arm       = r_arm;
        n_j         = r_j;
        n_len       = r_len;
        n_first     = r_first;
        n_cur       = r_cur;
        n_prod      = r_prod;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pos   = r_out_pos;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        o_pop_ready = 1'b0;
        wr_addr     = rd_addr;
        we_inc      = 1'b0;
        we_tgt      = 1'b0;
        we_cur      = 1'b0;
        wr_inc_data = i_pop_cmd.value;
        wr_cur_data = r_inc_rd;
        fill_now    = r_fill[i_pop_cmd.arm];

        case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    if (i_pop_cmd.op == OP_TARGET) begin
                        if (fill_now < CW'(MAX_JOINTS)) begin
                            we_inc   = 1'b1;
                            wr_addr  = store_addr(i_pop_cmd.arm, fill_now);
                            fill_now = fill_now + CW'(1);
                        end
                        n_fill[i_pop_cmd.arm] = fill_now;
                        if (i_pop_cmd.last) begin
                            n_fill[i_pop_cmd.arm]  = '0;
                            n_ticks[i_pop_cmd.arm] = '0;
                            n_len   = fill_now;
                            n_arm   = i_pop_cmd.arm;
                            n_j     = '0;
                            n_first = !r_valid[i_pop_cmd.arm];
                            if (!r_valid[i_pop_cmd.arm]) begin
                                n_jc[i_pop_cmd.arm]    = fill_now;
                                n_valid[i_pop_cmd.arm] = 1'b1;
                                n_mism[i_pop_cmd.arm]  = 1'b0;
                            end else begin
                                n_mism[i_pop_cmd.arm] = (fill_now != r_jc[i_pop_cmd.arm]);
                            end
                            n_state = ST_CP_RD;
                        end
                    end else begin
                        for (int a = 0; a < NUM_ARMS; a++) begin
                            if (r_ticks[a] != 16'hFFFF) begin
                                n_ticks[a] = r_ticks[a] + 16'd1;
                            end
                            n_smooth[a] = (n_ticks[a] <= i_cfg.timeout) && !r_mism[a];
                        end
                        n_arm   = 1'b0;
                        n_state = ST_ARM;
                    end
                end
            end
            ST_CP_RD: begin
                n_state = ST_CP_WR;
            end
            ST_CP_WR: begin
                we_tgt = 1'b1;
                we_cur = r_first;
                n_j    = r_j + CW'(1);
                if (r_j == r_len - CW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CP_RD;
                end
            end
            ST_ARM: begin
                if (r_valid[r_arm]) begin
                    n_j     = '0;
                    n_state = ST_RD;
                end else if (r_arm == LAST_ARM) begin
                    n_state = ST_IDLE;
                end else begin
                    n_arm = r_arm + 1'b1;
                end
            end
            ST_RD: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_cur   = $signed(r_cur_rd);
                n_prod  = diff * $signed({1'b0, i_cfg.alpha});
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_step  = r_smooth[r_arm] ? sum_step : '0;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    we_cur      = 1'b1;
                    wr_cur_data = sat;
                    n_out_valid = 1'b1;
                    n_out_pos   = sat;
                    n_out_user  = {i_cfg.follow, j6[2:0], r_arm};
                    n_out_last  = 1'b0;
                    n_j         = r_j + CW'(1);
                    if (r_j == r_jc[r_arm] - CW'(1)) begin
                        if ((r_arm == LAST_ARM) || !later_valid) begin
                            n_out_last = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_arm   = r_arm + 1'b1;
                            n_state = ST_ARM;
                        end
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_arm       <= 1'b0;
            r_j         <= '0;
            r_len       <= '0;
            r_first     <= 1'b0;
            for (int a = 0; a < NUM_ARMS; a++) begin
                r_fill[a]   <= '0;
                r_jc[a]     <= '0;
                r_valid[a]  <= 1'b0;
                r_mism[a]   <= 1'b0;
                r_ticks[a]  <= '0;
                r_smooth[a] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_arm       <= n_arm;
            r_j         <= n_j;
            r_len       <= n_len;
            r_first     <= n_first;
            r_fill      <= n_fill;
            r_jc        <= n_jc;
            r_valid     <= n_valid;
            r_mism      <= n_mism;
            r_ticks     <= n_ticks;
            r_smooth    <= n_smooth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_prod     <= n_prod;
        r_step     <= n_step;
        r_out_pos  <= n_out_pos;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        r_inc_rd <= mem_inc[rd_addr];
        r_tgt_rd <= mem_tgt[rd_addr];
        r_cur_rd <= mem_cur[rd_addr];
        if (we_inc) begin
            mem_inc[wr_addr] <= wr_inc_data;
        end
        if (we_tgt) begin
            mem_tgt[wr_addr] <= r_inc_rd;
        end
        if (we_cur) begin
            mem_cur[wr_addr] <= wr_cur_data;
        end
    end

    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_SUM)
        else $error("result loaded outside the sum stage");

    a_copy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CP_RD |-> (r_len != '0) && (r_j < r_len))
        else $error("commit copy index out of range");

    for (genvar g = 0; g < NUM_ARMS; g++) begin : g_arm_chk
        a_jc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_valid[g] |-> (r_jc[g] != '0) && (r_jc[g] <= CW'(MAX_JOINTS)))
            else $error("valid arm with bad joint count");
    end

endmodule

`default_nettype wire

// ===== dv/jts_checker.sv =====
// Checker for the joint target smoother: watches the configuration, input and
// result channels, predicts the joint reports of every tick and compares them.
// Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [31:0] i_s_tdata,    // angle
    input  wire  [1:0]  i_s_tuser,    // operation, arm
    input  wire         i_s_tlast,    // last_element
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,    // position
    input  wire  [4:0]  i_m_tuser,    // out_arm, joint[2:0], follow
    input  wire         i_m_tlast,    // last
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output int          o_error_count,
    output int          o_pending_count
);
    import jts_pkg::*;

    localparam int NJ = DEF_MAX_JOINTS;
    localparam int NA = DEF_NUM_ARMS;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MIN = -64'sd2147483648;

    typedef struct packed {
        logic        arm;
        logic [2:0]  joint;
        logic [31:0] position;
        logic        follow;
        logic        last;
    } t_joint_report;

    logic [16:0] alpha_q16;
    logic [30:0] step_limit;
    logic        limit_on;
    logic [15:0] hold_after;
    logic        deg_input;
    logic        follow_copy;

    logic signed [31:0] position_now  [NA*NJ];
    logic signed [31:0] position_goal [NA*NJ];
    logic signed [31:0] goal_shadow   [NA*NJ];
    int                 shadow_fill   [NA];
    int                 joints_in_arm [NA];
    bit                 arm_live      [NA];
    bit                 length_changed[NA];
    int                 ticks_idle    [NA];

    t_joint_report expected_reports[$];
    int            errors;

    function automatic logic signed [31:0] degrees_to_radians(input logic signed [31:0] deg);
        longint prod;
        prod = longint'(deg) * longint'(DEG_TO_RAD_Q32);
        return 32'(prod >>> 32);
    endfunction

    function automatic logic signed [31:0] ema_move(input logic signed [31:0] cur,
                                                    input logic signed [31:0] goal);
        longint step;
        longint lim;
        longint sum;
        step = ((longint'(goal) - longint'(cur)) * longint'(alpha_q16)) >>> 16;
        lim  = longint'(step_limit);
        if (limit_on) begin
            if (step > lim)
                step = lim;
            else if (step < -lim)
                step = -lim;
        end
        sum = longint'(cur) + step;
        if (sum > POS_MAX)
            sum = POS_MAX;
        else if (sum < NEG_MIN)
            sum = NEG_MIN;
        return 32'(sum);
    endfunction

    task automatic commit_arm(input int a);
        int base;
        base = a * NJ;
        for (int j = 0; j < shadow_fill[a]; j++)
            position_goal[base + j] = goal_shadow[base + j];
        if (!arm_live[a]) begin
            for (int j = 0; j < shadow_fill[a]; j++)
                position_now[base + j] = goal_shadow[base + j];
            joints_in_arm[a]  = shadow_fill[a];
            arm_live[a]       = 1'b1;
            length_changed[a] = 1'b0;
        end else begin
            length_changed[a] = (shadow_fill[a] != joints_in_arm[a]);
        end
        ticks_idle[a]  = 0;
        shadow_fill[a] = 0;
    endtask

    task automatic take_element(input int a, input logic signed [31:0] angle,
                                input logic last_flag);
        logic signed [31:0] val;
        val = deg_input ? degrees_to_radians(angle) : angle;
        // elements past the last joint are dropped
        if (shadow_fill[a] < NJ) begin
            goal_shadow[a*NJ + shadow_fill[a]] = val;
            shadow_fill[a]++;
        end
        if (last_flag)
            commit_arm(a);
    endtask

    task automatic predict_tick();
        int total;
        int k;
        for (int a = 0; a < NA; a++) begin
            if (ticks_idle[a] < 65535)
                ticks_idle[a]++;
            if (arm_live[a] && ticks_idle[a] <= int'(hold_after) && !length_changed[a]) begin
                for (int j = 0; j < joints_in_arm[a]; j++)
                    position_now[a*NJ + j] = ema_move(position_now[a*NJ + j],
                                                      position_goal[a*NJ + j]);
            end
        end
        total = 0;
        for (int a = 0; a < NA; a++)
            if (arm_live[a])
                total += joints_in_arm[a];
        k = 0;
        for (int a = 0; a < NA; a++) begin
            if (arm_live[a]) begin
                for (int j = 0; j < joints_in_arm[a]; j++) begin
                    expected_reports.push_back('{arm: 1'(a), joint: 3'(j),
                                                 position: position_now[a*NJ + j],
                                                 follow: follow_copy,
                                                 last: (k == total - 1)});
                    k++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_report();
        t_joint_report want;
        if (expected_reports.size() == 0) begin
            $error("unexpected result: tuser %0h position %0h", i_m_tuser, i_m_tdata);
            errors++;
        end else begin
            want = expected_reports.pop_front();
            check_field("out_arm", 32'(want.arm), 32'(i_m_tuser[0]));
            check_field("joint", 32'(want.joint), 32'(i_m_tuser[3:1]));
            check_field("position", want.position, i_m_tdata);
            check_field("follow", 32'(want.follow), 32'(i_m_tuser[4]));
            check_field("last", 32'(want.last), 32'(i_m_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha_q16   = RST_ALPHA;
            step_limit  = RST_MAX_STEP;
            limit_on    = RST_LIMIT_EN;
            hold_after  = RST_TIMEOUT;
            deg_input   = RST_CONV_DEG;
            follow_copy = RST_FOLLOW;
            for (int a = 0; a < NA; a++) begin
                shadow_fill[a]    = 0;
                joints_in_arm[a]  = 0;
                arm_live[a]       = 1'b0;
                length_changed[a] = 1'b0;
                ticks_idle[a]     = 0;
            end
            expected_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ALPHA:    alpha_q16   = i_cfg_data[16:0];
                    CFG_MAX_STEP: step_limit  = i_cfg_data[30:0];
                    CFG_LIMIT_EN: limit_on    = i_cfg_data[0];
                    CFG_TIMEOUT:  hold_after  = i_cfg_data[15:0];
                    CFG_CONV_DEG: deg_input   = i_cfg_data[0];
                    CFG_FOLLOW:   follow_copy = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_TICK)
                    predict_tick();
                else
                    take_element(int'(i_s_tuser[1]), i_s_tdata, i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready)
                check_report();
        end
        o_error_count   <= errors;
        o_pending_count <= expected_reports.size();
    end

endmodule

// ===== dv/tb_joint_target_smoother.sv =====
// Testbench top for the joint target smoother: clock, reset, target and tick
// stimulus, receiver stalls and the verdict. Depends on jts_pkg, the RTL and
// jts_checker.
`timescale 1ns / 1ps

module tb_joint_target_smoother;
    import jts_pkg::*;

    localparam int JOINTS          = DEF_MAX_JOINTS;
    localparam int SETTLE_CYCLES   = 100;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam logic [31:0] CORNER_ANGLES [10] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
        32'h005A_0000, 32'hFF4C_0000, 32'h00B4_0000, 32'h0001_0000, 32'hFFFF_0000
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;
    wire  [4:0]  m_tuser;
    wire         m_tlast;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int error_count;
    int pending_count;
    bit gaps_on;
    int burst_left;
    bit rx_hold_req;

    joint_target_smoother u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jts_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always #6 clk = ~clk;

    initial begin
        #(64'd10_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: rotates through ready patterns, long hold on request
    initial begin : rx_side
        int cycle;
        cycle = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            cycle++;
            case ((cycle / 256) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ((cycle % 7) >= 3);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            5:       return CORNER_ANGLES[$urandom_range(0, 3)];
            default: return 32'($urandom_range(0, 720 * 65536)) - 32'(360 * 65536);
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic arm, input logic [31:0] data,
                             input logic last_flag);
        s_tvalid <= 1'b1;
        s_tuser  <= {arm, op};
        s_tdata  <= data;
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else if (gaps_on) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 1'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_vector(input logic arm, input int len);
        for (int k = 0; k < len; k++)
            send_item(OP_TARGET, arm, pick_angle(), (k == len - 1));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes every register; bits above each field carry junk
    task automatic load_config(input logic [16:0] alpha, input logic [30:0] max_step,
                               input logic lim_en, input logic [15:0] tmo,
                               input logic conv, input logic follow);
        t_cfg_idx    idx;
        logic [31:0] word;
        idx = idx.first();
        do begin
            word = $urandom();
            case (idx)
                CFG_ALPHA:    word[16:0] = alpha;
                CFG_MAX_STEP: word[30:0] = max_step;
                CFG_LIMIT_EN: word[0]    = lim_en;
                CFG_TIMEOUT:  word[15:0] = tmo;
                CFG_CONV_DEG: word[0]    = conv;
                CFG_FOLLOW:   word[0]    = follow;
                default: ;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= word;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            idx = idx.next();
        end while (idx != idx.first());
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n);
        int   sent;
        int   pick;
        int   len;
        logic arm;
        sent = 0;
        while (sent < n) begin
            arm  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 19);
            len  = 0;
            if (pick <= 10) begin
                send_tick();
                sent++;
            end else if (pick <= 16) begin
                len = JOINTS;
            end else if (pick == 17) begin
                len = $urandom_range(1, JOINTS - 1);     // size change, arm holds
            end else if (pick == 18) begin
                len = $urandom_range(JOINTS + 1, JOINTS + 3);
            end else begin
                send_item(OP_TARGET, arm, $urandom(), 1'($urandom_range(0, 1)));
                sent++;
            end
            if (len > 0) begin
                send_vector(arm, len);
                sent += len;
            end
        end
    endtask

    initial begin : stimulus
        gaps_on     = 1'b1;
        burst_left  = 0;
        rx_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: tick with no arm, overlong first vector, size change
        send_tick();
        for (int k = 0; k < 10; k++)
            send_item(OP_TARGET, 1'b0, CORNER_ANGLES[k], (k == 9));
        send_tick();
        send_vector(1'b1, JOINTS);
        send_tick();
        send_vector(1'b1, 2);
        send_tick();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_config(17'd65536, 31'h7FFF_FFFF, 1'b1, 16'hFFFF, 1'b0, 1'b1);
                1: load_config(17'd0, 31'd0, 1'b1, 16'd0, 1'b1, 1'b0);
                2: load_config(17'($urandom_range(0, 65536)), 31'($urandom_range(0, 4000)),
                               1'b1, 16'($urandom_range(1, 6)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                3: load_config(17'($urandom_range(0, 65536)), 31'($urandom()), 1'b0,
                               16'($urandom_range(0, 40)), 1'b0, 1'b1);
                5: load_config(17'd65536, 31'h7FFF_FFFF, 1'b0, 16'd100, 1'b0, 1'b0);
                default: load_config(17'($urandom_range(0, 65536)), 31'($urandom()),
                                     1'($urandom_range(0, 1)), 16'($urandom()),
                                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            if (ph == 4) begin
                // receiver holds off while ticks keep coming
                gaps_on     = 1'b0;
                rx_hold_req = 1'b1;
                repeat (12) send_tick();
            end
            gaps_on = ((ph % 3) != 2);
            random_traffic(ITEMS_PER_PHASE);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
